>>> rtl/decimal_list_to_fixed_point_assert.svh
// Assertion macros used by the decimal_list_to_fixed_point RTL module.
`ifndef DECIMAL_LIST_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_LIST_TO_FIXED_POINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dlfp_pkg.sv
`timescale 1ns / 1ps
package dlfp_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned FracW      = 10;
  localparam int unsigned CountW     = 8;
  localparam int unsigned MagW       = 42;
  localparam int unsigned ScaleInt   = 1000;

  localparam logic [CountW-1:0] MaxItemsReset = 8'd5;
  localparam logic [1:0]        MaxFracDigits = 2'd3;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharClose = 8'h5D;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEEK,
    PH_INT,
    PH_FRAC,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic              negative;
    logic [ValueW-1:0] int_acc;
    logic [FracW-1:0]  frac_acc;
    logic [1:0]        frac_digits;
    logic              saw_digit;
  } num_t;

endpackage

>>> rtl/dlfp_scale.sv
`timescale 1ns / 1ps
module dlfp_scale (
  input  dlfp_pkg::num_t                    num_i,
  output logic signed [dlfp_pkg::ValueW-1:0] value_o
);
  import dlfp_pkg::*;

  logic [MagW-1:0] prod;
  logic [16:0]     frac_scaled;
  logic [MagW-1:0] mag;

  always_comb begin
    prod = MagW'(num_i.int_acc) * MagW'(ScaleInt);
    case (num_i.frac_digits)
      2'd1:    frac_scaled = 17'(num_i.frac_acc) * 17'd100;
      2'd2:    frac_scaled = 17'(num_i.frac_acc) * 17'd10;
      2'd3:    frac_scaled = 17'(num_i.frac_acc);
      default: frac_scaled = '0;
    endcase
    mag = prod + MagW'(frac_scaled);
    if (num_i.negative) begin
      if (mag > MagW'(64'h8000_0000)) begin
        value_o = {1'b1, {(ValueW-1){1'b0}}};
      end else begin
        value_o = ValueW'(-mag);
      end
    end else begin
      if (mag > MagW'(64'h7FFF_FFFF)) begin
        value_o = {1'b0, {(ValueW-1){1'b1}}};
      end else begin
        value_o = ValueW'(mag);
      end
    end
  end

endmodule

>>> rtl/decimal_list_to_fixed_point.sv
`timescale 1ns / 1ps
// A character is captured in the input register; when the parse step fires, its result goes to the output register.
// Throughput: one item per cycle; a character is taken every cycle unless the output stalls.
// The rate is set by the single parse step between the input register and the output register.
// Reset: parse idle, number and count cleared, no item held, max_items set to 5.
module decimal_list_to_fixed_point (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dlfp_pkg::CountW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          char_byte_i,
  input  logic                                start_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dlfp_pkg::ValueW-1:0]  value_o,
  output logic                                value_valid_o,
  output logic [dlfp_pkg::CountW-1:0]         index_o,
  output logic                                done_res_o
);
  import dlfp_pkg::*;

  logic [CountW-1:0] max_items_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       start_q;

  phase_e            phase_q, phase_d;
  num_t              num_q, num_d;
  logic [CountW-1:0] count_q, count_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] value_q;
  logic                     value_valid_q;
  logic [CountW-1:0]        index_q;
  logic                     done_q;

  logic                     slot_free, fire, in_accept;
  logic                     emit, res_valid, res_done;
  logic [CountW-1:0]        res_idx;
  logic signed [ValueW-1:0] scaled;

  phase_e            cur_phase;
  num_t              cur_num;
  logic [CountW-1:0] cur_count;
  logic [CountW-1:0] count_inc;
  logic              is_digit, is_end, go_int, do_close;
  logic [3:0]        digit;
  logic [35:0]       int_next;
  logic [12:0]       frac_next;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && slot_free;
  assign in_ready_o = !in_valid_q || slot_free;
  assign in_accept  = in_valid_i && in_ready_o;

  dlfp_scale u_scale (
    .num_i   (num_q),
    .value_o (scaled)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    cur_phase = phase_q;
    cur_num   = num_q;
    cur_count = count_q;
    if (start_q) begin
      cur_phase = PH_SEEK;
      cur_num   = '0;
      cur_count = '0;
    end

    is_digit  = char_q inside {[CharZero:CharNine]};
    is_end    = (char_q == CharNul) || (char_q == CharClose);
    digit     = 4'(char_q - CharZero);
    int_next  = 36'({cur_num.int_acc, 3'b000}) + 36'({cur_num.int_acc, 1'b0}) + 36'(digit);
    frac_next = 13'({cur_num.frac_acc, 3'b000}) + 13'({cur_num.frac_acc, 1'b0}) + 13'(digit);
    count_inc = cur_count + 8'd1;

    phase_d   = cur_phase;
    num_d     = cur_num;
    count_d   = cur_count;
    emit      = 1'b0;
    res_valid = 1'b0;
    res_done  = 1'b0;
    res_idx   = cur_count;
    go_int    = 1'b0;
    do_close  = 1'b0;

    case (cur_phase)
      PH_SEEK: begin
        if (cur_count >= max_items_q || is_end) begin
          emit     = 1'b1;
          res_done = 1'b1;
        end else if (char_q == CharComma || char_q == CharSpace) begin
          phase_d = PH_SEEK;
        end else if (char_q == CharMinus) begin
          num_d.negative = 1'b1;
          phase_d        = PH_INT;
        end else begin
          phase_d = PH_INT;
          go_int  = 1'b1;
        end
      end
      PH_INT: begin
        go_int = 1'b1;
      end
      PH_FRAC: begin
        if (is_digit && cur_num.frac_digits < MaxFracDigits) begin
          num_d.frac_acc    = FracW'(frac_next);
          num_d.frac_digits = cur_num.frac_digits + 2'd1;
        end else begin
          do_close = 1'b1;
        end
      end
      PH_TAIL: begin
        if (is_end) begin
          emit     = 1'b1;
          res_done = 1'b1;
        end else if (char_q == CharComma) begin
          phase_d = PH_SEEK;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (go_int) begin
      if (is_digit) begin
        num_d.int_acc   = (int_next[35:32] != 4'd0) ? '1 : int_next[31:0];
        num_d.saw_digit = 1'b1;
      end else if (char_q == CharDot) begin
        phase_d = PH_FRAC;
      end else begin
        do_close = 1'b1;
      end
    end

    if (do_close) begin
      emit = 1'b1;
      if (!cur_num.saw_digit) begin
        res_done = 1'b1;
      end else begin
        res_valid = 1'b1;
        count_d   = count_inc;
        num_d     = '0;
        res_done  = (count_inc >= max_items_q) || is_end;
        phase_d   = (char_q == CharComma) ? PH_SEEK : PH_TAIL;
      end
    end

    if (res_done) begin
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= MaxItemsReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      num_q       <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_items_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q <= phase_d;
        num_q   <= num_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q  <= char_byte_i;
      start_q <= start_req_i;
    end
    if (fire && emit) begin
      value_q       <= res_valid ? scaled : '0;
      value_valid_q <= res_valid;
      index_q       <= res_idx;
      done_q        <= res_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign value_valid_o = value_valid_q;
  assign index_o       = index_q;
  assign done_res_o    = done_q;

`include "decimal_list_to_fixed_point_assert.svh"

  `DLFP_ASSERT_IMP(a_empty_is_done, out_valid_q && !value_valid_q, done_q && value_q == '0, "bad empty")
  `DLFP_ASSERT_NXT(a_done_goes_idle, fire && emit && res_done, phase_q == PH_IDLE, "not idle")
  `DLFP_ASSERT_IMP(a_idle_silent, fire && phase_q == PH_IDLE && !start_q, !emit, "idle result")
  `DLFP_ASSERT_IMP(a_count_tracks, out_valid_q && value_valid_q, count_q == 8'(index_q + 8'd1), "count off")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dlfp_pkg::*;

  localparam int StallLimit = 1000;
  localparam int LongHold   = 80;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_RESULT
  } row_kind_e;

  typedef struct {
    logic [7:0]         ch;
    logic               st;
    row_kind_e          kind;
    logic signed [31:0] v;
    logic               vl;
    logic [7:0]         ix;
    logic               dn;
  } row_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     vld;
    logic [CountW-1:0]        idx;
    logic                     done;
  } result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CountW-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               char_byte_i;
  logic                     start_req_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [ValueW-1:0] value_o;
  logic                     value_valid_o;
  logic [CountW-1:0]        index_o;
  logic                     done_res_o;

  decimal_list_to_fixed_point i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .start_req_i   (start_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .value_valid_o (value_valid_o),
    .index_o       (index_o),
    .done_res_o    (done_res_o)
  );

  result_t pending_values[$];
  result_t seen_want;
  int      mismatch_count = 0;
  int      item_count = 0;
  int      quiet_cycles = 0;
  int      new_results = 0;
  bit      hold_long = 0;
  bit      no_idle = 0;

  // parser shadow state
  logic [CountW-1:0] p_limit;
  phase_e            p_phase;
  logic              p_neg;
  logic [ValueW-1:0] p_int;
  logic [FracW-1:0]  p_frac;
  logic [1:0]        p_fdig;
  logic              p_saw;
  logic [CountW-1:0] p_count;

  row_t dir_rows [0:24];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h", field, got, want);
    mismatch_count++;
  endtask

  task automatic clear_number();
    p_neg  = 1'b0;
    p_int  = '0;
    p_frac = '0;
    p_fdig = '0;
    p_saw  = 1'b0;
  endtask

  task automatic push_value(input logic signed [31:0] v, input logic vl,
                            input logic [7:0] ix, input logic dn);
    result_t r;
    r.value = v;
    r.vld   = vl;
    r.idx   = ix;
    r.done  = dn;
    pending_values.push_back(r);
    new_results++;
    if (dn) p_phase = PH_IDLE;
  endtask

  task automatic close_number(input logic [7:0] c);
    longint     mag;
    longint     sv;
    logic [7:0] ix;
    logic       dn;
    if (!p_saw) begin
      push_value('0, 1'b0, p_count, 1'b1);
      return;
    end
    mag = {32'b0, p_int};
    mag = mag * 1000;
    case (p_fdig)
      2'd1: mag = mag + longint'(p_frac) * 100;
      2'd2: mag = mag + longint'(p_frac) * 10;
      2'd3: mag = mag + longint'(p_frac);
      default: ;
    endcase
    if (p_neg) begin
      sv = -mag;
      if (sv < -64'sd2147483648) sv = -64'sd2147483648;
    end else begin
      sv = mag;
      if (sv > 64'sd2147483647) sv = 64'sd2147483647;
    end
    ix = p_count;
    p_count = p_count + 8'd1;
    clear_number();
    dn = (p_count >= p_limit) || c == CharNul || c == CharClose;
    if (!dn) p_phase = (c == CharComma) ? PH_SEEK : PH_TAIL;
    push_value(sv[31:0], 1'b1, ix, dn);
  endtask

  task automatic parse_char(input logic [7:0] c, input logic st);
    longint acc;
    logic   digit;
    digit = c >= CharZero && c <= CharNine;
    if (st) begin
      clear_number();
      p_count = '0;
      p_phase = PH_SEEK;
    end
    if (p_phase == PH_SEEK) begin
      if (p_count >= p_limit || c == CharNul || c == CharClose) begin
        push_value('0, 1'b0, p_count, 1'b1);
        return;
      end
      if (c == CharComma || c == CharSpace) return;
      p_phase = PH_INT;
      if (c == CharMinus) begin
        p_neg = 1'b1;
        return;
      end
    end
    case (p_phase)
      PH_INT: begin
        if (digit) begin
          acc = {32'b0, p_int};
          acc = acc * 10 + longint'(c - CharZero);
          p_int = (acc > 64'sd4294967295) ? 32'hFFFF_FFFF : acc[31:0];
          p_saw = 1'b1;
        end else if (c == CharDot) begin
          p_phase = PH_FRAC;
        end else begin
          close_number(c);
        end
      end
      PH_FRAC: begin
        if (digit && p_fdig < MaxFracDigits) begin
          p_frac = FracW'(p_frac * 10 + FracW'(c - CharZero));
          p_fdig = p_fdig + 2'd1;
        end else begin
          close_number(c);
        end
      end
      PH_TAIL: begin
        if (c == CharNul || c == CharClose) push_value('0, 1'b0, p_count, 1'b1);
        else if (c == CharComma) p_phase = PH_SEEK;
      end
      default: p_phase = PH_IDLE;
    endcase
  endtask

  task automatic send_item(input row_t r);
    int      gap;
    result_t typed;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= r.ch;
    start_req_i <= r.st;
    do @(posedge clk_i); while (!in_ready_o);
    new_results = 0;
    parse_char(r.ch, r.st);
    if (r.kind != ROW_PREDICT) begin
      repeat (new_results) void'(pending_values.pop_back());
      if (r.kind == ROW_RESULT) begin
        typed.value = r.v;
        typed.vld   = r.vl;
        typed.idx   = r.ix;
        typed.done  = r.dn;
        pending_values.push_back(typed);
      end
    end
    item_count++;
    @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c, input logic st);
    row_t r;
    r = '{c, st, ROW_PREDICT, 0, 1'b0, 8'd0, 1'b0};
    send_item(r);
  endtask

  task automatic send_list();
    logic [8:0] text[$];
    int         nums;
    int         nd;
    int         pick;
    logic [7:0] fill;
    if ($urandom_range(0, 7) == 0) begin
      nums = $urandom_range(1, 10);
      repeat (nums) text.push_back({($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255))});
    end else begin
      nums = $urandom_range(1, 6);
      for (int k = 0; k < nums; k++) begin
        if ($urandom_range(0, 3) == 0)
          text.push_back({1'b0, ($urandom_range(0, 1) ? CharSpace : CharComma)});
        if ($urandom_range(0, 3) == 0) text.push_back({1'b0, CharMinus});
        pick = $urandom_range(0, 19);
        nd = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 11) : $urandom_range(1, 4);
        repeat (nd) text.push_back({1'b0, CharZero + 8'($urandom_range(0, 9))});
        if ($urandom_range(0, 1)) begin
          text.push_back({1'b0, CharDot});
          nd = $urandom_range(0, 4);
          repeat (nd) text.push_back({1'b0, CharZero + 8'($urandom_range(0, 9))});
        end
        if ($urandom_range(0, 4) == 0) begin
          fill = 8'($urandom_range(0, 255));
          text.push_back({1'b0, fill});
        end
        if (k < nums - 1) text.push_back({1'b0, CharComma});
        else text.push_back({1'b0, ($urandom_range(0, 3) == 0) ? CharNul : CharClose});
      end
      text[0][8] = 1'b1;
    end
    foreach (text[i]) send_char(text[i][7:0], text[i][8]);
  endtask

  task automatic set_limit(input logic [CountW-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    p_limit = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    int target;
    target = item_count + n_items;
    while (item_count < target) send_list();
  endtask

  // output side
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_long = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        report("unexpected result", value_o, 32'h0);
      end else begin
        seen_want = pending_values.pop_front();
        if (value_o !== seen_want.value) report("value", value_o, seen_want.value);
        if (value_valid_o !== seen_want.vld)
          report("value_valid", 32'(value_valid_o), 32'(seen_want.vld));
        if (index_o !== seen_want.idx) report("index", 32'(index_o), 32'(seen_want.idx));
        if (done_res_o !== seen_want.done)
          report("done_res", 32'(done_res_o), 32'(seen_want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    char_byte_i = '0;
    start_req_i = 1'b0;
    p_limit     = MaxItemsReset;
    p_phase     = PH_IDLE;
    p_count     = '0;
    clear_number();

    dir_rows = '{
      '{"x",      1'b0, ROW_SILENT,  0,           1'b0, 8'd0, 1'b0},
      '{"1",      1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"2",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharDot,  1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"5",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharComma,1'b0, ROW_RESULT,  32'sd12500,  1'b1, 8'd0, 1'b0},
      '{CharSpace,1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharMinus,1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharDot,  1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"a",      1'b0, ROW_RESULT,  0,           1'b0, 8'd1, 1'b1},
      '{"7",      1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"9",      1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{8'hFF,    1'b0, ROW_RESULT,  32'sd9000,   1'b1, 8'd0, 1'b0},
      '{CharClose,1'b0, ROW_RESULT,  0,           1'b0, 8'd1, 1'b1},
      '{CharMinus,1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"9",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharDot,  1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"0",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"0",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"1",      1'b0, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{"5",      1'b0, ROW_RESULT,  -32'sd9001,  1'b1, 8'd0, 1'b0},
      '{CharNul,  1'b0, ROW_RESULT,  0,           1'b0, 8'd1, 1'b1},
      '{"3",      1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0},
      '{CharNul,  1'b0, ROW_RESULT,  32'sd3000,   1'b1, 8'd0, 1'b1},
      '{"4",      1'b1, ROW_PREDICT, 0,           1'b0, 8'd0, 1'b0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    set_limit(8'd1);
    run_phase(80);
    set_limit(8'd255);
    hold_long = 1;
    run_phase(120);
    set_limit(8'd0);
    run_phase(40);
    set_limit(8'd3);
    no_idle = 1;
    run_phase(90);
    no_idle = 0;
    set_limit(8'($urandom_range(1, 255)));
    run_phase(100);
    set_limit(MaxItemsReset);
    run_phase(100);

    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
